/* sv/water_level_debounce_pump_control_top_assert.svh */
// ----------------------------------------------------------------------------
// Water level debounce and pump control: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WATER_LEVEL_DEBOUNCE_PUMP_CONTROL_TOP_ASSERT_SVH
`define WATER_LEVEL_DEBOUNCE_PUMP_CONTROL_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WLDPC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wldpc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define WLDPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wldpc assertion failed");

`endif

/* sv/wldpc_pkg.sv */
// ----------------------------------------------------------------------------
// Water level debounce and pump control: package
// Message codes, register indexes, reset values and the lane result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wldpc_pkg;

	localparam int CFG_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int NUM_LANES = 2;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_SECOND = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FILL_DELAY_SECONDS = 2'd2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_LIMIT_RST = 16'd500;
	localparam logic [CFG_WIDTH-1:0] TICKS_PER_SECOND_RST = 16'd1000;
	localparam logic [CFG_WIDTH-1:0] FILL_DELAY_SECONDS_RST = 16'd120;

	typedef logic [1:0] msg_t;
	localparam msg_t MSG_NONE = 2'd0;
	localparam msg_t MSG_HIGH = 2'd1;
	localparam msg_t MSG_LOW = 2'd2;

	typedef struct packed {
		logic level_high;
		msg_t msg;
	} lane_res_t;

endpackage

`default_nettype wire

/* sv/water_level_debounce_pump_control_top.sv */
// ----------------------------------------------------------------------------
// Water level debounce and pump control: top level
// A result is registered and appears on the output in the cycle after its item is accepted.
// Throughput is one item per cycle while m_tready does not stall the output, set by the single update of
// lane and service state per accepted item; the output register decouples the sides.
// Reset clears all debounce, timer and pump state and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module water_level_debounce_pump_control_top #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// level1_sample [0], level2_sample [1], hold [2], zero [7:3]
	input  wire logic [7:0]                            s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// level1_high [0], level2_high [1], level1_msg [3:2], level2_msg [5:4],
	// pump_on [6], stop_request [7]
	output logic [7:0]                                 m_tdata,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [wldpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [wldpc_pkg::CFG_WIDTH-1:0]       cfg_data
);
	import wldpc_pkg::*;

	logic [CFG_WIDTH-1:0] debounce_limit_q, ticks_per_second_q, fill_delay_seconds_q;
	logic accept;
	logic out_valid_q;
	logic [7:0] out_data_q;
	lane_res_t lane_res [NUM_LANES];
	logic pump_on, stop_request;

	assign cfg_ready = 1'b1;
	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= DEBOUNCE_LIMIT_RST;
			ticks_per_second_q <= TICKS_PER_SECOND_RST;
			fill_delay_seconds_q <= FILL_DELAY_SECONDS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_data;
				REG_TICKS_PER_SECOND: ticks_per_second_q <= cfg_data;
				REG_FILL_DELAY_SECONDS: fill_delay_seconds_q <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		wldpc_lane #(
			.COUNTER_WIDTH(COUNTER_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(accept),
			.sample (s_tdata[g]),
			.limit  (debounce_limit_q),
			.res    (lane_res[g])
		);
	end

	wldpc_service #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_service (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (accept),
		.hold              (s_tdata[2]),
		.lane1             (lane_res[0]),
		.lane2             (lane_res[1]),
		.ticks_per_second  (ticks_per_second_q),
		.fill_delay_seconds(fill_delay_seconds_q),
		.pump_on           (pump_on),
		.stop_request      (stop_request)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {stop_request, pump_on, lane_res[1].msg, lane_res[0].msg,
				lane_res[1].level_high, lane_res[0].level_high};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

`include "water_level_debounce_pump_control_top_assert.svh"

	`WLDPC_ASSERT_NEXT(a_accept_gives_result, accept, m_tvalid)
	`WLDPC_ASSERT_SAME(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready)
	`WLDPC_ASSERT_SAME(a_high_msg_sets_level1, m_tvalid && m_tdata[3:2] == MSG_HIGH, m_tdata[0])
	`WLDPC_ASSERT_SAME(a_low_msg_clears_level2, m_tvalid && m_tdata[5:4] == MSG_LOW, !m_tdata[1])

endmodule

`default_nettype wire

/* sv/wldpc_lane.sv */
// ----------------------------------------------------------------------------
// Water level debounce and pump control: debounce lane
// Debounces one level switch in both directions and reports confirmations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wldpc_lane #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           advance,
	input  wire logic                           sample,
	input  wire logic [wldpc_pkg::CFG_WIDTH-1:0] limit,
	output wldpc_pkg::lane_res_t                res
);
	import wldpc_pkg::*;

	localparam int CMP_WIDTH = (COUNTER_WIDTH > CFG_WIDTH) ? COUNTER_WIDTH : CFG_WIDTH;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	logic [COUNTER_WIDTH-1:0] high_count_q, low_count_q, high_count_d, low_count_d;
	logic [COUNTER_WIDTH-1:0] high_inc, low_inc;
	logic high_locked_q, low_locked_q, level_q;
	logic high_locked_d, low_locked_d, level_d;
	logic [CMP_WIDTH-1:0] limit_ext;
	msg_t msg;

	assign limit_ext = CMP_WIDTH'(limit);
	assign high_inc = (high_count_q == CNT_MAX) ? CNT_MAX : high_count_q + 1'b1;
	assign low_inc = (low_count_q == CNT_MAX) ? CNT_MAX : low_count_q + 1'b1;

	always_comb begin
		high_count_d = high_count_q;
		low_count_d = low_count_q;
		high_locked_d = high_locked_q;
		low_locked_d = low_locked_q;
		level_d = level_q;
		msg = MSG_NONE;
		if (sample) begin
			low_locked_d = 1'b0;
			low_count_d = '0;
			if (!high_locked_q) begin
				high_count_d = high_inc;
				if (CMP_WIDTH'(high_inc) > limit_ext) begin
					high_count_d = '0;
					high_locked_d = 1'b1;
					level_d = 1'b1;
					msg = MSG_HIGH;
				end
			end
		end else if (!low_locked_q) begin
			high_locked_d = 1'b0;
			high_count_d = '0;
			low_count_d = low_inc;
			if (CMP_WIDTH'(low_inc) > limit_ext) begin
				low_count_d = '0;
				low_locked_d = 1'b1;
				level_d = 1'b0;
				msg = MSG_LOW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_count_q <= '0;
			low_count_q <= '0;
			high_locked_q <= 1'b0;
			low_locked_q <= 1'b0;
			level_q <= 1'b0;
		end else if (advance) begin
			high_count_q <= high_count_d;
			low_count_q <= low_count_d;
			high_locked_q <= high_locked_d;
			low_locked_q <= low_locked_d;
			level_q <= level_d;
		end
	end

	assign res.level_high = level_d;
	assign res.msg = msg;

endmodule

`default_nettype wire

/* sv/wldpc_service.sv */
// ----------------------------------------------------------------------------
// Water level debounce and pump control: pump service
// Merges the lane results into the fill arming, delay timer and pump drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wldpc_service #(
	parameter int COUNTER_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            advance,
	input  wire logic                            hold,
	input  wire wldpc_pkg::lane_res_t            lane1,
	input  wire wldpc_pkg::lane_res_t            lane2,
	input  wire logic [wldpc_pkg::CFG_WIDTH-1:0] ticks_per_second,
	input  wire logic [wldpc_pkg::CFG_WIDTH-1:0] fill_delay_seconds,
	output logic                                 pump_on,
	output logic                                 stop_request
);
	import wldpc_pkg::*;

	localparam int CMP_WIDTH = (COUNTER_WIDTH > CFG_WIDTH) ? COUNTER_WIDTH : CFG_WIDTH;
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

	logic [COUNTER_WIDTH-1:0] tick_count_q, second_count_q, tick_count_d, second_count_d;
	logic [COUNTER_WIDTH-1:0] tick_inc, second_inc;
	logic fill_armed_q, pump_running_q, fill_armed_d, pump_running_d;
	logic armed;
	logic stop;

	assign armed = fill_armed_q | (lane2.msg == MSG_HIGH);
	assign tick_inc = (tick_count_q == CNT_MAX) ? CNT_MAX : tick_count_q + 1'b1;
	assign second_inc = (second_count_q == CNT_MAX) ? CNT_MAX : second_count_q + 1'b1;

	always_comb begin
		tick_count_d = tick_count_q;
		second_count_d = second_count_q;
		fill_armed_d = armed;
		pump_running_d = pump_running_q;
		stop = 1'b0;
		if (!hold) begin
			if (armed) begin
				if (!lane2.level_high) begin
					tick_count_d = tick_inc;
					if (CMP_WIDTH'(tick_inc) >= CMP_WIDTH'(ticks_per_second)) begin
						tick_count_d = '0;
						second_count_d = second_inc;
					end
					if (CMP_WIDTH'(second_count_d) > CMP_WIDTH'(fill_delay_seconds)) begin
						second_count_d = '0;
						pump_running_d = 1'b1;
					end
				end
				if (pump_running_d && lane2.level_high) begin
					second_count_d = '0;
					pump_running_d = 1'b0;
				end
			end
			if (!lane1.level_high) begin
				fill_armed_d = 1'b0;
			end
			stop = !fill_armed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			second_count_q <= '0;
			fill_armed_q <= 1'b0;
			pump_running_q <= 1'b0;
		end else if (advance) begin
			tick_count_q <= tick_count_d;
			second_count_q <= second_count_d;
			fill_armed_q <= fill_armed_d;
			pump_running_q <= pump_running_d;
		end
	end

	assign pump_on = pump_running_d;
	assign stop_request = stop;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Water level debounce and pump control: testbench
// A queue of tick items feeds a stream driver; a cycle-accurate model of both
// debounce lanes, the fill timer and the pump predicts each result, and a
// monitor compares every field of every result in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import wldpc_pkg::*;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic hold;
		logic level2;
		logic level1;
	} tick_in_t;

	typedef struct packed {
		logic stop;
		logic pump;
		msg_t l2_msg;
		msg_t l1_msg;
		logic l2_high;
		logic l1_high;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_DEBOUNCE_LIMIT;
	logic [CFG_WIDTH-1:0] cfg_data = '0;

	water_level_debounce_pump_control_top #(
		.COUNTER_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Model state, cleared as the block is by reset.
	logic [CFG_WIDTH-1:0] cfg_debounce = DEBOUNCE_LIMIT_RST;
	logic [CFG_WIDTH-1:0] cfg_ticks = TICKS_PER_SECOND_RST;
	logic [CFG_WIDTH-1:0] cfg_fill = FILL_DELAY_SECONDS_RST;
	logic [CNT_W-1:0] high_count [2] = '{default: '0};
	logic [CNT_W-1:0] low_count [2] = '{default: '0};
	logic high_locked [2] = '{default: 1'b0};
	logic low_locked [2] = '{default: 1'b0};
	logic lane_high [2] = '{default: 1'b0};
	logic fill_armed = 1'b0;
	logic pump_running = 1'b0;
	logic [CNT_W-1:0] tick_count = '0;
	logic [CNT_W-1:0] second_count = '0;

	tick_in_t ticks_to_send [$];
	tick_result_t results_due [$];
	tick_in_t driven_tick;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int ticks_queued = 0;
	int ticks_accepted = 0;
	int results_checked = 0;
	int confirmations = 0;
	int pump_starts = 0;
	int settings_applied = 0;
	int error_count = 0;

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic msg_t debounce_lane(int ch, logic sample);
		msg_t m;
		m = MSG_NONE;
		if (sample) begin
			low_locked[ch] = 1'b0;
			low_count[ch] = '0;
			if (!high_locked[ch]) begin
				high_count[ch] = sat_inc(high_count[ch]);
				if (high_count[ch] > cfg_debounce) begin
					high_count[ch] = '0;
					high_locked[ch] = 1'b1;
					lane_high[ch] = 1'b1;
					m = MSG_HIGH;
				end
			end
		end else if (!low_locked[ch]) begin
			high_locked[ch] = 1'b0;
			high_count[ch] = '0;
			low_count[ch] = sat_inc(low_count[ch]);
			if (low_count[ch] > cfg_debounce) begin
				low_count[ch] = '0;
				low_locked[ch] = 1'b1;
				lane_high[ch] = 1'b0;
				m = MSG_LOW;
			end
		end
		if (m != MSG_NONE)
			confirmations++;
		return m;
	endfunction

	// Level 2 is scanned before level 1, and both before the pump service.
	function automatic tick_result_t control_step(tick_in_t t);
		tick_result_t r;
		r.l2_msg = debounce_lane(1, t.level2);
		if (r.l2_msg == MSG_HIGH)
			fill_armed = 1'b1;
		r.l1_msg = debounce_lane(0, t.level1);
		r.stop = 1'b0;
		if (!t.hold) begin
			if (fill_armed) begin
				if (!lane_high[1]) begin
					tick_count = sat_inc(tick_count);
					if (tick_count >= cfg_ticks) begin
						tick_count = '0;
						second_count = sat_inc(second_count);
					end
					if (second_count > cfg_fill) begin
						second_count = '0;
						if (!pump_running)
							pump_starts++;
						pump_running = 1'b1;
					end
				end
				if (pump_running && lane_high[1]) begin
					second_count = '0;
					pump_running = 1'b0;
				end
			end
			if (!lane_high[0])
				fill_armed = 1'b0;
			if (!fill_armed)
				r.stop = 1'b1;
		end
		r.l1_high = lane_high[0];
		r.l2_high = lane_high[1];
		r.pump = pump_running;
		return r;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			results_due.push_back(control_step(driven_tick));
			ticks_accepted++;
		end
		if (!s_tvalid || s_tready) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (ticks_to_send.size() != 0 && src_idle_pct != 0 &&
					$urandom_range(0, 99) < src_idle_pct) begin
				src_gap = $urandom_range(0, 4);
				s_tvalid <= 1'b0;
			end else if (ticks_to_send.size() != 0) begin
				driven_tick = ticks_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'd0, driven_tick};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : monitor
		tick_result_t got;
		tick_result_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (results_due.size() == 0) begin
				$error("unexpected result item %h", m_tdata);
				error_count++;
			end else begin
				want = results_due.pop_front();
				check_field("level1_high", 2'(want.l1_high), 2'(got.l1_high));
				check_field("level2_high", 2'(want.l2_high), 2'(got.l2_high));
				check_field("level1_msg", want.l1_msg, got.l1_msg);
				check_field("level2_msg", want.l2_msg, got.l2_msg);
				check_field("pump_on", 2'(want.pump), 2'(got.pump));
				check_field("stop_request", 2'(want.stop), 2'(got.stop));
				results_checked++;
			end
		end
		if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
			sink_gap = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE_LIMIT: cfg_debounce = val;
			REG_TICKS_PER_SECOND: cfg_ticks = val;
			REG_FILL_DELAY_SECONDS: cfg_fill = val;
			default: ;
		endcase
	endtask

	task automatic configure(logic [CFG_WIDTH-1:0] debounce, logic [CFG_WIDTH-1:0] ticks,
			logic [CFG_WIDTH-1:0] fill);
		write_register(REG_DEBOUNCE_LIMIT, debounce);
		write_register(REG_TICKS_PER_SECOND, ticks);
		write_register(REG_FILL_DELAY_SECONDS, fill);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic push_run(logic l1, logic l2, int n, int noise_pct, int hold_pct);
		tick_in_t t;
		repeat (n) begin
			t.level1 = l1 ^ ($urandom_range(0, 99) < noise_pct);
			t.level2 = l2 ^ ($urandom_range(0, 99) < noise_pct);
			t.hold = $urandom_range(0, 99) < hold_pct;
			ticks_to_send.push_back(t);
			ticks_queued++;
		end
	endtask

	// Confirm level 1, arm on level 2, let the timer start the pump, stop it on
	// level 2 and sometimes disarm by dropping level 1.
	task automatic push_fill_cycle(int noise_pct, int hold_pct);
		int settle;
		longint low_len;
		settle = cfg_debounce + 1;
		low_len = settle + longint'(cfg_ticks == 0 ? 1 : cfg_ticks) * (cfg_fill + 2) +
			$urandom_range(0, 3);
		if (low_len > 80)
			low_len = 80;
		push_run(1'b1, 1'b0, settle + $urandom_range(0, 2), noise_pct, hold_pct);
		push_run(1'b1, 1'b1, settle + $urandom_range(0, 2), noise_pct, hold_pct);
		push_run(1'b1, 1'b0, int'(low_len), noise_pct, hold_pct);
		push_run(1'b1, 1'b1, settle + $urandom_range(0, 2), noise_pct, hold_pct);
		if ($urandom_range(0, 1))
			push_run(1'b0, 1'($urandom_range(0, 1)), settle + $urandom_range(0, 2), noise_pct,
				hold_pct);
	endtask

	task automatic drain_ticks();
		while (ticks_accepted != ticks_queued || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random_phase(int n_ticks);
		int target;
		target = ticks_queued + n_ticks;
		while (ticks_queued < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: push_fill_cycle($urandom_range(0, 3), $urandom_range(0, 8));
				6: push_run(1'b0, 1'b0, $urandom_range(1, 12), 50, 50);
				7: push_run(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(1, cfg_debounce + 1), 0, 5);
				8: push_run(1'b1, 1'($urandom_range(0, 1)), $urandom_range(1, 10), 0, 100);
				default: push_run(1'b0, 1'b0, cfg_debounce + 2, 2, 0);
			endcase
		end
		drain_ticks();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 20;
		sink_stall_pct = 20;
		for (int c = 0; c < 8; c++)
			push_run(c[0], c[1], 1, 0, c[2] ? 100 : 0);
		drain_ticks();

		configure(16'd0, 16'd0, 16'd0);
		push_run(1'b1, 1'b0, 1, 0, 0);
		push_run(1'b1, 1'b1, 1, 0, 0);
		push_run(1'b1, 1'b0, 1, 0, 0);
		push_run(1'b1, 1'b0, 1, 0, 100);
		push_run(1'b1, 1'b1, 1, 0, 0);
		push_run(1'b1, 1'b0, 2, 0, 0);
		push_run(1'b0, 1'b0, 1, 0, 0);
		push_run(1'b0, 1'b1, 1, 0, 100);
		push_run(1'b0, 1'b1, 1, 0, 0);
		drain_ticks();

		configure(16'd1, 16'd1, 16'd1);
		run_random_phase(300);
		configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
			16'($urandom_range(0, 5)));
		run_random_phase(340);

		src_idle_pct = 0;
		sink_stall_pct = 0;
		configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
			16'($urandom_range(0, 5)));
		run_random_phase(340);

		src_idle_pct = 30;
		sink_stall_pct = 30;
		configure(16'd2, 16'hFFFF, 16'hFFFE);
		push_fill_cycle(0, 0);
		push_fill_cycle(1, 5);
		drain_ticks();
		configure(16'hFFFF, 16'd0, 16'hFFFF);
		push_run(1'b0, 1'b0, 30, 50, 50);
		push_run(1'b1, 1'b1, 10, 0, 0);
		drain_ticks();

		src_idle_pct = 25;
		sink_stall_pct = 25;
		configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
			16'($urandom_range(0, 5)));
		run_random_phase(400);

		src_idle_pct = 0;
		sink_stall_pct = 0;
		configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
			16'($urandom_range(0, 5)));
		run_random_phase(300);

		$display("%0d ticks accepted, %0d results checked over %0d register settings",
			ticks_accepted, results_checked, settings_applied);
		$display("%0d level confirmations and %0d pump starts predicted",
			confirmations, pump_starts);
		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
